/* hw/rtl/tcf_pkg.sv */
// shared constants, register indexes and arctangent table for the tilt filter
package tcf_pkg;

	localparam int ATAN_ENTRIES = 24;
	localparam int ZW           = 25;
	localparam int TILT_W       = 15;
	localparam int FUSED_W      = 16;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int MA_W         = 25;
	localparam int MB_W         = 18;
	localparam int PROD_W       = MA_W + MB_W;
	localparam int ACC_W        = 60;
	localparam int OUT_W        = 96;

	localparam logic [CFG_IDX_W-1:0] REG_BLEND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

	localparam logic [CFG_W-1:0]  BLEND_RESET = 16'd32113;
	localparam logic [CFG_W-1:0]  GAIN_RESET  = 16'd16393;
	localparam logic [CFG_W:0]    Q15_ONE     = 17'd32768;
	localparam logic [TILT_W-1:0] DEG90_Q7    = 15'd11520;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0:  v = 25'd2949120;
			5'd1:  v = 25'd1740967;
			5'd2:  v = 25'd919879;
			5'd3:  v = 25'd466945;
			5'd4:  v = 25'd234379;
			5'd5:  v = 25'd117304;
			5'd6:  v = 25'd58666;
			5'd7:  v = 25'd29335;
			5'd8:  v = 25'd14668;
			5'd9:  v = 25'd7334;
			5'd10: v = 25'd3667;
			5'd11: v = 25'd1833;
			5'd12: v = 25'd917;
			5'd13: v = 25'd458;
			5'd14: v = 25'd229;
			5'd15: v = 25'd115;
			5'd16: v = 25'd57;
			5'd17: v = 25'd29;
			5'd18: v = 25'd14;
			5'd19: v = 25'd7;
			5'd20: v = 25'd4;
			5'd21: v = 25'd2;
			5'd22: v = 25'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/tcf_isqrt.sv */
// digit-serial integer square root, two radicand bits per cycle
module tcf_isqrt #(
	parameter int VW = 48,
	parameter int RW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] radicand,
	output logic          done,
	output logic [RW-1:0] root
);
	localparam int CNT_W = $clog2(RW + 1);

	logic [VW-1:0]    rad_q;
	logic [RW+2:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RW+2:0]    rem_sh;
	logic [RW+2:0]    trial;
	logic             ge;

	assign rem_sh = {rem_q[RW:0], rad_q[VW-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hw/rtl/tcf_cordic.sv */
// iterative vectoring cordic giving atan(num/den) in 1/128 degree
module tcf_cordic
	import tcf_pkg::*;
#(
	parameter int CW    = 27,
	parameter int STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [CW-1:0]            num,
	input  logic signed [CW-1:0]            den,
	output logic                            done,
	output logic signed [tcf_pkg::TILT_W-1:0] angle
);
	localparam int NSTEP = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
	localparam int IW    = $clog2(NSTEP + 1);

	logic signed [CW-1:0]     x_q, y_q, xs, ys;
	logic signed [ZW-1:0]     z_q, zc, rsum;
	logic [IW-1:0]            i_q;
	logic                     neg_q, busy_q, done_q, spec_q;
	logic signed [TILT_W-1:0] angle_q;
	logic [ZW-1:0]            at;
	logic [ZW-10:0]           r_mag;
	logic [TILT_W-1:0]        mag;

	assign xs    = x_q >>> i_q;
	assign ys    = y_q >>> i_q;
	assign at    = atan_entry(5'(i_q));
	assign zc    = z_q[ZW-1] ? '0 : z_q;
	assign rsum  = zc + ZW'(256);
	assign r_mag = rsum[ZW-1:9];
	assign mag   = (r_mag > (ZW-9)'(DEG90_Q7)) ? DEG90_Q7 : TILT_W'(r_mag);

	// zero operands still run the full count so all lanes finish together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (i_q == IW'(NSTEP)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= den[CW-1] ? -den : den;
			y_q    <= num[CW-1] ? -num : num;
			z_q    <= '0;
			neg_q  <= num[CW-1] ^ den[CW-1];
			spec_q <= (num == '0) || (den == '0);
			if (num == '0) begin
				angle_q <= '0;
			end else if (den == '0) begin
				angle_q <= num[CW-1] ? -$signed(DEG90_Q7) : $signed(DEG90_Q7);
			end
		end else if (busy_q) begin
			if (i_q == IW'(NSTEP)) begin
				if (!spec_q) begin
					angle_q <= neg_q ? -$signed(mag) : $signed(mag);
				end
			end else if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + $signed(at);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - $signed(at);
			end
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

/* hw/rtl/tcf_blend.sv */
// complementary blend with one shared multiplier and the fused angle state
module tcf_blend
	import tcf_pkg::*;
#(
	parameter int SW = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [SW-1:0]               rate,
	input  logic signed [tcf_pkg::TILT_W-1:0]  tilt,
	input  logic [tcf_pkg::CFG_W:0]            weight,
	input  logic [tcf_pkg::CFG_W-1:0]          gain,
	output logic                               done,
	output logic signed [tcf_pkg::FUSED_W-1:0] fused
);
	localparam int QW = ACC_W - 39;

	logic [2:0]                step_q;
	logic                      busy_q, done_q;
	logic signed [FUSED_W-1:0] fused_q;
	logic signed [MA_W-1:0]    ma;
	logic signed [MB_W-1:0]    mb;
	logic signed [PROD_W-1:0]  prod_q, p_q, p_hi;
	logic signed [ACC_W-1:0]   acc_q, prod_ext, prod_up, sum;
	logic signed [QW-1:0]      q;
	logic                      ovf;

	assign p_hi = p_q >>> 24;

	always_comb begin
		case (step_q)
			3'd0: begin
				ma = MA_W'(rate);
				mb = $signed({2'b00, gain});
			end
			3'd1: begin
				ma = MA_W'(fused_q);
				mb = $signed({1'b0, weight});
			end
			3'd2: begin
				ma = MA_W'(tilt);
				mb = $signed({1'b0, Q15_ONE - weight});
			end
			3'd3: begin
				ma = MA_W'(p_hi);
				mb = $signed({1'b0, weight});
			end
			3'd4: begin
				ma = $signed({1'b0, p_q[23:0]});
				mb = $signed({1'b0, weight});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);
	assign prod_up  = prod_ext <<< 24;
	assign sum      = acc_q + (ACC_W'(1) <<< 38);
	assign q        = sum[ACC_W-1:39];
	assign ovf      = !(&q[QW-1:FUSED_W-1] || ~|q[QW-1:FUSED_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
			fused_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'd6) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (ovf) begin
						fused_q <= q[QW-1] ? 16'sh8000 : 16'sh7fff;
					end else begin
						fused_q <= q[FUSED_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (step_q)
			3'd1: p_q <= prod_q;
			3'd2: acc_q <= prod_up;
			3'd3: acc_q <= acc_q + prod_up;
			3'd4: acc_q <= acc_q + prod_up;
			3'd5: acc_q <= acc_q + prod_ext;
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign fused = fused_q;

endmodule

/* hw/rtl/tilt_complementary_filter.sv */
// top level: accelerometer tilt angles and complementary filter on three axes
//
//  channel  direction  word                                         handshake
//  s_*      in         accel x/y/z, rate x/y/z                      tvalid/tready
//  m_*      out        tilt x/y/z, fused x/y/z                      tvalid/tready
//  cfg_*    in         register index, data                         valid/ready
//
//  a word is taken only in idle, so the next word waits until this one is loaded for output
//  after accept each word passes the squares, the root, the cordic (steps capped at 24) and
//  the blend unit in that order, then the output step
//  all three axes run in lockstep, each with its own root, cordic and blend unit
//  reset clears the fused angles and loads the register defaults
//  a finished word waits in the output register while the next word is taken;
//  a word still held there stalls the next one before its output step
module tilt_complementary_filter
	import tcf_pkg::*;
#(
	parameter int CORDIC_STEPS = 16,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tilt_x, tilt_y, tilt_z, fused_x, fused_y, fused_z
	output logic [tcf_pkg::OUT_W-1:0]         m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcf_pkg::CFG_W-1:0]         cfg_data
);
	localparam int S  = SAMPLE_BITS;
	localparam int VW = 2 * S + 16;
	localparam int RW = S + 8;
	localparam int CW = S + 11;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQA   = 4'd1;
	localparam logic [3:0] ST_SQB   = 4'd2;
	localparam logic [3:0] ST_ROOT  = 4'd3;
	localparam logic [3:0] ST_RWAIT = 4'd4;
	localparam logic [3:0] ST_ATAN  = 4'd5;
	localparam logic [3:0] ST_AWAIT = 4'd6;
	localparam logic [3:0] ST_BLEND = 4'd7;
	localparam logic [3:0] ST_BWAIT = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]                state_q;
	logic [CFG_W-1:0]          blend_q, gain_q;
	logic [CFG_W:0]            weight;
	logic signed [S-1:0]       accel_q [3];
	logic signed [S-1:0]       rate_q [3];
	logic [2:0]                root_done, atan_done, blend_done;
	logic signed [TILT_W-1:0]  tilt [3];
	logic signed [FUSED_W-1:0] fused [3];
	logic                      m_valid_q;
	logic [OUT_W-1:0]          out_q;
	logic                      out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign weight    = ({1'b0, blend_q} > Q15_ONE) ? Q15_ONE : {1'b0, blend_q};
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= BLEND_RESET;
			gain_q  <= GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLEND: blend_q <= cfg_data;
				REG_GAIN:  gain_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			for (int k = 0; k < 3; k++) begin
				accel_q[k] <= s_tdata[k*S +: S];
				rate_q[k]  <= s_tdata[(k+3)*S +: S];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (s_tvalid) state_q <= ST_SQA;
				ST_SQA:   state_q <= ST_SQB;
				ST_SQB:   state_q <= ST_ROOT;
				ST_ROOT:  state_q <= ST_RWAIT;
				ST_RWAIT: if (root_done[0]) state_q <= ST_ATAN;
				ST_ATAN:  state_q <= ST_AWAIT;
				ST_AWAIT: if (atan_done[0]) state_q <= ST_BLEND;
				ST_BLEND: state_q <= ST_BWAIT;
				ST_BWAIT: if (blend_done[0]) state_q <= ST_OUT;
				ST_OUT:   if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int IA = (k == 0) ? 1 : 0;
		localparam int IB = (k == 2) ? 1 : 2;

		logic [2*S-1:0]       sqa_q, sum_q;
		logic signed [2*S-1:0] pa, pb;
		logic [RW-1:0]        root;
		logic signed [CW-1:0] num, den, own;

		assign pa = accel_q[IA] * accel_q[IA];
		assign pb = accel_q[IB] * accel_q[IB];

		always_ff @(posedge clk) begin
			if (state_q == ST_SQA) sqa_q <= pa;
			if (state_q == ST_SQB) sum_q <= sqa_q + pb;
		end

		tcf_isqrt #(.VW(VW), .RW(RW)) u_root (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (state_q == ST_ROOT),
			.radicand ({sum_q, 16'b0}),
			.done     (root_done[k]),
			.root     (root)
		);

		assign own = CW'(accel_q[k]) <<< 8;
		if (k == 2) begin : g_z
			assign num = $signed(CW'(root));
			assign den = own;
		end else begin : g_xy
			assign num = own;
			assign den = $signed(CW'(root));
		end

		tcf_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_atan (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_ATAN),
			.num    (num),
			.den    (den),
			.done   (atan_done[k]),
			.angle  (tilt[k])
		);

		tcf_blend #(.SW(S)) u_blend (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_BLEND),
			.rate   (rate_q[k]),
			.tilt   (tilt[k]),
			.weight (weight),
			.gain   (gain_q),
			.done   (blend_done[k]),
			.fused  (fused[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {3'b000, fused[2], fused[1], fused[0], tilt[2], tilt[1], tilt[0]};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTH
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(root_done[0] == root_done[1]) && (root_done[0] == root_done[2]))
		else $error("root units out of step");
	a_atan_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(atan_done[0] == atan_done[1]) && (atan_done[0] == atan_done[2]))
		else $error("cordic units out of step");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SQA))
		else $error("accepted word did not start");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented");
`endif

endmodule

/* tb/tb_tilt_complementary_filter.sv */
// testbench for the tilt complementary filter: random and directed samples checked against a predictor
module tb_tilt_complementary_filter;
	import tcf_pkg::*;

	typedef struct packed {
		logic signed [15:0] fz, fy, fx;
		logic signed [14:0] tz, ty, tx;
	} tilt_word_t;

	class tilt_scoreboard;
		logic [15:0] weight;
		logic [15:0] gain;
		logic signed [15:0] angle [3];
		tilt_word_t pending [$];
		int errors;
		int checked;

		function void clear();
			weight = BLEND_RESET;
			gain = GAIN_RESET;
			for (int k = 0; k < 3; k++) angle[k] = 0;
			pending = {};
			errors = 0;
			checked = 0;
		endfunction

		function longint root(longint v);
			longint r, b;
			r = 0;
			b = 64'sd1 <<< 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - r - b;
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		function longint arctan(longint num, longint den);
			longint x, y, z, xs, ys, r;
			bit neg;
			if (num == 0) return 0;
			if (den == 0) return num > 0 ? 11520 : -11520;
			neg = (num < 0) != (den < 0);
			x = den < 0 ? -den : den;
			y = num < 0 ? -num : num;
			z = 0;
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += atan_entry(i[4:0]);
				end else begin
					x -= ys; y += xs; z -= atan_entry(i[4:0]);
				end
			end
			if (z < 0) z = 0;
			r = (z + 256) >>> 9;
			if (r > 11520) r = 11520;
			return neg ? -r : r;
		endfunction

		function logic signed [15:0] mix(logic signed [15:0] prev, longint rate, longint tilt);
			longint w, path, acc, r;
			w = weight > 32768 ? 32768 : weight;
			path = (longint'(prev) <<< 24) + rate * longint'(gain);
			acc = w * path + (32768 - w) * (tilt <<< 24);
			r = (acc + (64'sd1 <<< 38)) >>> 39;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[15:0];
		endfunction

		function void note_sample(logic [95:0] d);
			longint a [3], g [3], t [3];
			tilt_word_t e;
			for (int k = 0; k < 3; k++) begin
				a[k] = longint'($signed(d[16*k +: 16]));
				g[k] = longint'($signed(d[48 + 16*k +: 16]));
			end
			t[0] = arctan(a[0] * 256, root((a[1]*a[1] + a[2]*a[2]) <<< 16));
			t[1] = arctan(a[1] * 256, root((a[0]*a[0] + a[2]*a[2]) <<< 16));
			t[2] = arctan(root((a[0]*a[0] + a[1]*a[1]) <<< 16), a[2] * 256);
			for (int k = 0; k < 3; k++) angle[k] = mix(angle[k], g[k], t[k]);
			e.tx = t[0][14:0]; e.ty = t[1][14:0]; e.tz = t[2][14:0];
			e.fx = angle[0]; e.fy = angle[1]; e.fz = angle[2];
			pending.push_back(e);
		endfunction

		function void check_word(logic [95:0] d);
			tilt_word_t e, got;
			got = d[92:0];
			if (pending.size() == 0) begin
				$error("unexpected output word %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.tx !== e.tx) begin $error("tilt_x exp %0d got %0d", e.tx, got.tx); errors++; end
			if (got.ty !== e.ty) begin $error("tilt_y exp %0d got %0d", e.ty, got.ty); errors++; end
			if (got.tz !== e.tz) begin $error("tilt_z exp %0d got %0d", e.tz, got.tz); errors++; end
			if (got.fx !== e.fx) begin $error("fused_x exp %0d got %0d", e.fx, got.fx); errors++; end
			if (got.fy !== e.fy) begin $error("fused_y exp %0d got %0d", e.fy, got.fy); errors++; end
			if (got.fz !== e.fz) begin $error("fused_z exp %0d got %0d", e.fz, got.fz); errors++; end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [95:0] s_tdata, m_tdata;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	tilt_scoreboard angle_board;
	int cycles;
	bit hold_off;

	tilt_complementary_filter i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("** tilt_complementary_filter: FAILED **");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int w;
		m_tready = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) angle_board.check_word(m_tdata);
			if (hold_off) begin
				m_tready <= 0;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end else if (m_tready && m_tvalid || !m_tready) begin
				w = $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0) w = 0;
				if (w == 0) m_tready <= 1;
				else begin
					m_tready <= 0;
					repeat (w) @(posedge clk);
					m_tready <= 1;
				end
			end
		end
	end

	task automatic send_sample(logic [95:0] d);
		int w;
		w = $urandom_range(0, 3);
		if (w > 0) begin
			s_tvalid <= 0;
			repeat (w) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		angle_board.note_sample(d);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
		if (idx == REG_BLEND) angle_board.weight = v;
		else angle_board.gain = v;
	endtask

	task automatic settle();
		s_tvalid <= 0;
		while (angle_board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_run(int n);
		logic [95:0] d;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 6; k++) d[16*k +: 16] = pick_field();
			// in half the samples, plausible gravity vectors with small rates
			if ($urandom_range(0, 1)) begin
				d[47:32] = 16'($signed($urandom_range(0, 8192)) + 12000);
				for (int k = 3; k < 6; k++) d[16*k +: 16] = 16'($signed($urandom_range(0, 2000)) - 1000);
			end
			send_sample(d);
		end
	endtask

	initial begin
		logic [15:0] lim [6];
		angle_board = new();
		angle_board.clear();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_valid = 0;
		cfg_index = REG_BLEND;
		cfg_data = 0;
		hold_off = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		lim = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h1000};
		// zero vector, single axes, extremes, negative z
		send_sample(96'h0);
		send_sample({48'h7fff_7fff_7fff, 16'h0000, 16'h0000, 16'h7fff});
		send_sample({48'h8000_8000_8000, 16'h0000, 16'h8000, 16'h0000});
		send_sample({48'h0, 16'h8000, 16'h0000, 16'h0000});
		send_sample({48'h0, 16'h0000, 16'h0000, 16'h0000});
		send_sample({48'h0, 16'h8000, 16'h8000, 16'h8000});
		send_sample({48'h0, 16'h7fff, 16'h7fff, 16'h7fff});
		send_sample({48'h0, 16'hc000, 16'h0100, 16'hff00});
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 2; j++)
				send_sample({lim[(i+j)%6], lim[i], lim[5-i], lim[j], lim[i], lim[(i+3)%6]});
		random_run(300);
		hold_off = 1;
		random_run(100);
		settle();
		write_reg(REG_BLEND, 16'd32768);
		write_reg(REG_GAIN, 16'd65535);
		random_run(300);
		settle();
		write_reg(REG_BLEND, 16'd0);
		write_reg(REG_GAIN, 16'd0);
		random_run(250);
		settle();
		write_reg(REG_BLEND, 16'hffff);
		write_reg(REG_GAIN, 16'd40000);
		random_run(250);
		settle();
		write_reg(REG_BLEND, 16'($urandom_range(0, 32768)));
		write_reg(REG_GAIN, 16'($urandom));
		random_run(480);
		settle();
		$display("checked %0d output words over five register settings and a long output stall",
			angle_board.checked);
		if (angle_board.errors == 0 && angle_board.pending.size() == 0) begin
			$display("** tilt_complementary_filter: PASSED **");
		end else begin
			$display("** tilt_complementary_filter: FAILED **");
		end
		$finish;
	end
endmodule

/* filelist.f */
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_isqrt.sv
hw/rtl/tcf_cordic.sv
hw/rtl/tcf_blend.sv
hw/rtl/tilt_complementary_filter.sv
tb/tb_tilt_complementary_filter.sv
